// ===== rtl/core/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 30;
  localparam int RANK_W       = 3;
  localparam int TOTAL_W      = 32;
  localparam int HIT_COUNT_W  = 2;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;

  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  localparam int DEF_MAX_SET_BITS = 8;
  localparam int DEF_MAX_WAYS     = 8;

  typedef enum logic [1:0] {
    ACC_FETCH  = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_STORE  = 2'd2,
    ACC_MODIFY = 2'd3
  } access_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_BLOCK_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_t;

  typedef struct packed {
    logic hit;
    logic missed;
    logic evicted;
  } lookup_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sacl_if.sv =====
// ----------------------------------------------------------------------------
// sacl_if
// Valid/ready channels: access input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacl_access_if import sacl_pkg::*;;
  logic                valid;
  logic                ready;
  access_kind_t        access_kind;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, output access_kind, output address, input ready);
  modport sink   (input valid, input access_kind, input address, output ready);
endinterface

interface sacl_result_if import sacl_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [HIT_COUNT_W-1:0] hit_count;
  logic                   missed;
  logic                   evicted;
  logic [TOTAL_W-1:0]     total_hits;
  logic [TOTAL_W-1:0]     total_misses;
  logic [TOTAL_W-1:0]     total_evictions;

  modport source (output valid, output hit_count, output missed, output evicted,
                  output total_hits, output total_misses, output total_evictions,
                  input ready);
  modport sink   (input valid, input hit_count, input missed, input evicted,
                  input total_hits, input total_misses, input total_evictions,
                  output ready);
endinterface

interface sacl_cfg_if import sacl_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sacl_addr_decode.sv =====
// ----------------------------------------------------------------------------
// sacl_addr_decode
// Clamps the geometry registers and splits an address into set and tag.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_addr_decode import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS
) (
  input  wire logic [SET_BITS_W-1:0]   set_bits,
  input  wire logic [BLOCK_BITS_W-1:0] block_bits,
  input  wire logic [ADDR_W-1:0]       address,
  output logic      [MAX_SET_BITS-1:0] set_index,
  output logic      [TAG_W-1:0]        tag
);

  logic [5:0]              sb_eff;
  logic [BLOCK_BITS_W-1:0] bb_eff;
  logic [5:0]              split;
  logic [ADDR_W-1:0]       set_shift;
  logic [ADDR_W-1:0]       tag_shift;
  logic [MAX_SET_BITS-1:0] set_mask;

  always_comb begin
    sb_eff = 6'(set_bits);
    if (set_bits == '0) begin
      sb_eff = 6'd1;
    end else if (6'(set_bits) > 6'(MAX_SET_BITS)) begin
      sb_eff = 6'(MAX_SET_BITS);
    end
    bb_eff = (block_bits == '0) ? BLOCK_BITS_W'(1) : block_bits;
    split  = sb_eff + 6'(bb_eff);
  end

  always_comb begin
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      set_mask[i] = (6'(i) < sb_eff);
    end
  end

  assign set_shift = address >> bb_eff;
  assign tag_shift = address >> split[4:0];
  assign set_index = set_shift[MAX_SET_BITS-1:0] & set_mask;
  assign tag       = (split < 6'd32) ? tag_shift[TAG_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== rtl/core/sacl_tag_store.sv =====
// ----------------------------------------------------------------------------
// sacl_tag_store
// One row per set holding valid, rank and tag of every way, with live flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_tag_store import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                rd_en,
  input  wire logic [MAX_SET_BITS-1:0]             rd_set,
  input  wire logic                                wr_en,
  input  wire logic [MAX_SET_BITS-1:0]             wr_set,
  input  wire logic [MAX_WAYS-1:0]                 wr_valid,
  input  wire logic [MAX_WAYS-1:0][RANK_W-1:0]     wr_rank,
  input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]      wr_tag,
  output logic      [MAX_WAYS-1:0]                 rd_valid,
  output logic      [MAX_WAYS-1:0][RANK_W-1:0]     rd_rank,
  output logic      [MAX_WAYS-1:0][TAG_W-1:0]      rd_tag
);

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int ROW_W = MAX_WAYS * (1 + RANK_W + TAG_W);

  logic [ROW_W-1:0]                mem [SETS];
  logic [SETS-1:0]                 row_live;
  logic [ROW_W-1:0]                rd_row;
  logic                            rd_live;
  logic [MAX_WAYS-1:0]             row_valid;
  logic [MAX_WAYS-1:0][RANK_W-1:0] row_rank;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  row_tag;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= {wr_valid, wr_rank, wr_tag};
    end
    if (rd_en) begin
      rd_row <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_live <= '0;
      rd_live  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_live[wr_set] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= row_live[rd_set];
      end
    end
  end

  assign {row_valid, row_rank, row_tag} = rd_row;
  assign rd_valid = rd_live ? row_valid : '0;
  assign rd_rank  = rd_live ? row_rank : '0;
  assign rd_tag   = row_tag;

endmodule

`default_nettype wire

// ===== rtl/core/sacl_set_update.sv =====
// ----------------------------------------------------------------------------
// sacl_set_update
// Tag compare, fill or victim choice and recency update of one set row.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_set_update import sacl_pkg::*; #(
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input  wire logic [TAG_W-1:0]                tag,
  input  wire logic [WAYS_W-1:0]               ways_in_use,
  input  wire logic [MAX_WAYS-1:0]             old_valid,
  input  wire logic [MAX_WAYS-1:0][RANK_W-1:0] old_rank,
  input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]  old_tag,
  output lookup_status_t                       status,
  output logic      [MAX_WAYS-1:0]             new_valid,
  output logic      [MAX_WAYS-1:0][RANK_W-1:0] new_rank,
  output logic      [MAX_WAYS-1:0][TAG_W-1:0]  new_tag
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [4:0]          ways_eff;
  logic [MAX_WAYS-1:0] en;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    victim;
  logic [RANK_W-1:0]   best;
  logic [WAY_W-1:0]    touch_way;
  logic [RANK_W:0]     limit;
  logic                hit;
  logic                free_any;

  always_comb begin
    ways_eff = 5'(ways_in_use);
    if (ways_in_use == '0) begin
      ways_eff = 5'd1;
    end else if (5'(ways_in_use) > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      en[w]    = (5'(w) < ways_eff);
      match[w] = en[w] && old_valid[w] && (old_tag[w] == tag);
      free[w]  = en[w] && !old_valid[w];
    end
  end

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free[w]) begin
        free_way = WAY_W'(w);
      end
    end
    victim = '0;
    best   = old_rank[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (en[w] && (old_rank[w] > best)) begin
        best   = old_rank[w];
        victim = WAY_W'(w);
      end
    end
  end

  always_comb begin
    hit       = |match;
    free_any  = |free;
    touch_way = hit ? hit_way : (free_any ? free_way : victim);
    limit     = hit ? {1'b0, old_rank[hit_way]} : (RANK_W + 1)'(1 << RANK_W);
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_valid[w] = old_valid[w];
      new_tag[w]   = old_tag[w];
      new_rank[w]  = old_rank[w];
      if (touch_way == WAY_W'(w)) begin
        new_valid[w] = 1'b1;
        new_rank[w]  = '0;
        if (!hit) begin
          new_tag[w] = tag;
        end
      end else if (en[w] && old_valid[w] && ({1'b0, old_rank[w]} < limit) &&
                   (old_rank[w] != RANK_MAX)) begin
        new_rank[w] = old_rank[w] + RANK_W'(1);
      end
    end
    status.hit     = hit;
    status.missed  = !hit;
    status.evicted = !hit && !free_any;
  end

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_cache_lru_model_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_model_unit
// Set-associative cache model with LRU replacement and running totals.
//
// Channels: access (sink) takes access_kind and address; result (source)
// gives one item per access with hit_count, missed, evicted and the three
// saturating totals after that access; cfg (sink, always ready) writes
// set_bits (index 0), block_bits (1) and ways_in_use (2), other indexes
// are dropped. Write cfg only while no access is in flight.
// Timing: an access is taken in the idle state, its set row is read from
// the tag store at that edge, and in the lookup state the row is compared
// and updated; once the result register frees, it is written back (not for
// a fetch) while the result register loads. An item thus passes the row
// read and then the row write-back, and its result is registered.
// A new access is taken while a result waits; if the receiver stalls, the
// lookup holds until the result register frees, and access stays not ready.
// A modify is settled in the same pass: its store hit leaves the set as is.
// Reset clears the totals and the per-set live flags, so no clearing pass
// runs; registers return to set_bits 1, block_bits 1, ways_in_use 1.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_model_unit import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  sacl_access_if.sink   access,
  sacl_result_if.source result,
  sacl_cfg_if.sink      cfg
);

  state_t                          state;
  state_t                          state_next;
  logic [SET_BITS_W-1:0]           set_bits;
  logic [BLOCK_BITS_W-1:0]         block_bits;
  logic [WAYS_W-1:0]               ways_in_use;
  access_kind_t                    kind;
  logic [MAX_SET_BITS-1:0]         set_q;
  logic [TAG_W-1:0]                tag_q;
  logic [MAX_SET_BITS-1:0]         set_index;
  logic [TAG_W-1:0]                tag;
  logic                            take;
  logic                            advance;
  logic                            wr_en;
  logic [MAX_WAYS-1:0]             old_valid;
  logic [MAX_WAYS-1:0][RANK_W-1:0] old_rank;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  old_tag;
  logic [MAX_WAYS-1:0]             new_valid;
  logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;
  lookup_status_t                  status;
  lookup_status_t                  outcome;
  logic [HIT_COUNT_W-1:0]          hits;
  logic [TOTAL_W:0]                hit_sum;
  logic [TOTAL_W-1:0]              hit_total;
  logic [TOTAL_W-1:0]              miss_total;
  logic [TOTAL_W-1:0]              eviction_total;
  logic [TOTAL_W-1:0]              hit_total_next;
  logic [TOTAL_W-1:0]              miss_total_next;
  logic [TOTAL_W-1:0]              eviction_total_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_W'(1);
      block_bits  <= BLOCK_BITS_W'(1);
      ways_in_use <= WAYS_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SET_BITS:    set_bits    <= cfg.data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS:  block_bits  <= cfg.data[BLOCK_BITS_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg.data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  sacl_addr_decode #(
    .MAX_SET_BITS (MAX_SET_BITS)
  ) u_addr (
    .set_bits   (set_bits),
    .block_bits (block_bits),
    .address    (access.address),
    .set_index  (set_index),
    .tag        (tag)
  );

  sacl_tag_store #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (take),
    .rd_set   (set_index),
    .wr_en    (wr_en),
    .wr_set   (set_q),
    .wr_valid (new_valid),
    .wr_rank  (new_rank),
    .wr_tag   (new_tag),
    .rd_valid (old_valid),
    .rd_rank  (old_rank),
    .rd_tag   (old_tag)
  );

  sacl_set_update #(
    .MAX_WAYS (MAX_WAYS)
  ) u_update (
    .tag         (tag_q),
    .ways_in_use (ways_in_use),
    .old_valid   (old_valid),
    .old_rank    (old_rank),
    .old_tag     (old_tag),
    .status      (status),
    .new_valid   (new_valid),
    .new_rank    (new_rank),
    .new_tag     (new_tag)
  );

  always_comb begin
    state_next   = state;
    access.ready = 1'b0;
    advance      = 1'b0;
    case (state)
      ST_IDLE: begin
        access.ready = 1'b1;
        if (access.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        advance = !result.valid || result.ready;
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign take  = access.valid && access.ready;
  assign wr_en = advance && (kind != ACC_FETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind  <= access.access_kind;
      set_q <= set_index;
      tag_q <= tag;
    end
  end

  always_comb begin
    outcome = (kind == ACC_FETCH) ? '0 : status;
    hits    = HIT_COUNT_W'(outcome.hit) + HIT_COUNT_W'(kind == ACC_MODIFY);
    hit_sum = {1'b0, hit_total} + (TOTAL_W + 1)'(hits);
    hit_total_next      = hit_sum[TOTAL_W] ? '1 : hit_sum[TOTAL_W-1:0];
    miss_total_next     = miss_total;
    eviction_total_next = eviction_total;
    if (outcome.missed && (miss_total != '1)) begin
      miss_total_next = miss_total + TOTAL_W'(1);
    end
    if (outcome.evicted && (eviction_total != '1)) begin
      eviction_total_next = eviction_total + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
      result.valid   <= 1'b0;
    end else if (advance) begin
      hit_total      <= hit_total_next;
      miss_total     <= miss_total_next;
      eviction_total <= eviction_total_next;
      result.valid   <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.hit_count       <= hits;
      result.missed          <= outcome.missed;
      result.evicted         <= outcome.evicted;
      result.total_hits      <= hit_total_next;
      result.total_misses    <= miss_total_next;
      result.total_evictions <= eviction_total_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sacl_lru_monitor.sv =====
// ----------------------------------------------------------------------------
// sacl_lru_monitor
// Watches the access, result and register channels of the LRU cache model,
// tracks its own tag store, recency ranks and totals, and compares every
// result transfer field by field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_lru_monitor import sacl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  sacl_access_if    access_mon,
  sacl_result_if    result_mon,
  sacl_cfg_if       cfg_mon,
  output int        fail_count,
  output int        expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
  localparam logic [31:0] TAG_MASK = 32'h3FFF_FFFF;

  typedef enum logic [1:0] {
    LOOKUP_HIT,
    LOOKUP_FILL,
    LOOKUP_EVICT
  } lookup_outcome_t;

  typedef struct packed {
    logic [HIT_COUNT_W-1:0] hit_count;
    logic                   missed;
    logic                   evicted;
    logic [TOTAL_W-1:0]     total_hits;
    logic [TOTAL_W-1:0]     total_misses;
    logic [TOTAL_W-1:0]     total_evictions;
  } access_report_t;

  bit                tag_valid [LINES];
  logic [TAG_W-1:0]  tag_value [LINES];
  logic [RANK_W-1:0] tag_rank  [LINES];
  logic [TOTAL_W-1:0] hits_sum, misses_sum, evictions_sum;
  logic [SET_BITS_W-1:0]   set_bits_reg;
  logic [BLOCK_BITS_W-1:0] block_bits_reg;
  logic [WAYS_W-1:0]       ways_reg;
  access_report_t pending_reports [$];

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic void promote(input int base, input int ways, input int way,
                                  input int limit);
    for (int w = 0; w < ways; w++) begin
      if (w != way && tag_valid[base+w] && int'(tag_rank[base+w]) < limit &&
          tag_rank[base+w] < RANK_MAX) begin
        tag_rank[base+w] = tag_rank[base+w] + 1'b1;
      end
    end
    tag_rank[base+way] = '0;
  endfunction

  function automatic lookup_outcome_t probe(input logic [ADDR_W-1:0] addr);
    int sb, bb, ways, set_idx, base, victim;
    logic [31:0] shifted;
    logic [TAG_W-1:0] tag;
    logic [RANK_W-1:0] top_rank;
    sb = int'(set_bits_reg);
    if (sb < 1) sb = 1;
    if (sb > DEF_MAX_SET_BITS) sb = DEF_MAX_SET_BITS;
    bb = int'(block_bits_reg);
    if (bb < 1) bb = 1;
    ways = int'(ways_reg);
    if (ways < 1) ways = 1;
    if (ways > DEF_MAX_WAYS) ways = DEF_MAX_WAYS;
    set_idx = int'((addr >> bb) & ((32'd1 << sb) - 32'd1));
    shifted = (sb + bb < 32) ? ((addr >> (sb + bb)) & TAG_MASK) : 32'd0;
    tag = shifted[TAG_W-1:0];
    base = set_idx * DEF_MAX_WAYS;
    for (int w = 0; w < ways; w++) begin
      if (tag_valid[base+w] && tag_value[base+w] == tag) begin
        promote(base, ways, w, int'(tag_rank[base+w]));
        return LOOKUP_HIT;
      end
    end
    for (int w = 0; w < ways; w++) begin
      if (!tag_valid[base+w]) begin
        tag_valid[base+w] = 1'b1;
        tag_value[base+w] = tag;
        promote(base, ways, w, int'(RANK_MAX) + 1);
        return LOOKUP_FILL;
      end
    end
    victim = 0;
    top_rank = tag_rank[base];
    for (int w = 1; w < ways; w++) begin
      if (tag_rank[base+w] > top_rank) begin
        top_rank = tag_rank[base+w];
        victim = w;
      end
    end
    tag_value[base+victim] = tag;
    promote(base, ways, victim, int'(RANK_MAX) + 1);
    return LOOKUP_EVICT;
  endfunction

  function automatic access_report_t predict_access(input access_kind_t kind,
                                                    input logic [ADDR_W-1:0] addr);
    access_report_t rep;
    lookup_outcome_t first;
    rep = '0;
    if (kind != ACC_FETCH) begin
      first = probe(addr);
      if (first == LOOKUP_HIT) begin
        rep.hit_count = 2'd1;
        hits_sum = bump(hits_sum);
      end else begin
        rep.missed = 1'b1;
        misses_sum = bump(misses_sum);
        if (first == LOOKUP_EVICT) begin
          rep.evicted = 1'b1;
          evictions_sum = bump(evictions_sum);
        end
      end
      if (kind == ACC_MODIFY) begin
        void'(probe(addr));
        rep.hit_count = rep.hit_count + 2'd1;
        hits_sum = bump(hits_sum);
      end
    end
    rep.total_hits = hits_sum;
    rep.total_misses = misses_sum;
    rep.total_evictions = evictions_sum;
    return rep;
  endfunction

  always @(posedge clk) begin
    access_report_t want, got;
    if (rst) begin
      foreach (tag_valid[i]) begin
        tag_valid[i] = 1'b0;
        tag_rank[i] = '0;
      end
      hits_sum = '0;
      misses_sum = '0;
      evictions_sum = '0;
      set_bits_reg = 4'd1;
      block_bits_reg = 5'd1;
      ways_reg = 4'd1;
      pending_reports.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SET_BITS:    set_bits_reg = cfg_mon.data[SET_BITS_W-1:0];
          CFG_BLOCK_BITS:  block_bits_reg = cfg_mon.data[BLOCK_BITS_W-1:0];
          CFG_WAYS_IN_USE: ways_reg = cfg_mon.data[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) begin
        got.hit_count = result_mon.hit_count;
        got.missed = result_mon.missed;
        got.evicted = result_mon.evicted;
        got.total_hits = result_mon.total_hits;
        got.total_misses = result_mon.total_misses;
        got.total_evictions = result_mon.total_evictions;
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result transfer with no access outstanding", $realtime);
          end
        end else begin
          want = pending_reports.pop_front();
          if (got.hit_count !== want.hit_count || got.missed !== want.missed ||
              got.evicted !== want.evicted || got.total_hits !== want.total_hits ||
              got.total_misses !== want.total_misses ||
              got.total_evictions !== want.total_evictions) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch: expected hits=%0d missed=%0b evicted=%0b",
                       $realtime, want.hit_count, want.missed, want.evicted,
                       " totals=%0d/%0d/%0d", want.total_hits, want.total_misses,
                       want.total_evictions);
              $display("    got hits=%0d missed=%0b evicted=%0b totals=%0d/%0d/%0d",
                       got.hit_count, got.missed, got.evicted, got.total_hits,
                       got.total_misses, got.total_evictions);
            end
          end
        end
      end
      if (access_mon.valid && access_mon.ready) begin
        pending_reports.push_back(predict_access(access_mon.access_kind,
                                                 access_mon.address));
      end
    end
    expected_left = pending_reports.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_set_assoc_cache_lru_model_unit.sv =====
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_model_unit
// Drives directed and random memory accesses and register settings into the
// LRU cache model under random source gaps and sink stalls; the monitor
// predicts and checks every result and the verdict is printed at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_set_assoc_cache_lru_model_unit import sacl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam int GAP_MAX = 11;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 190;

  logic clk = 1'b0;
  logic rst;
  bit   gaps_on, stalls_on;
  int   fail_count, expected_left;
  int   eff_sb, eff_bb, eff_ways;
  logic [31:0] tag_pool [16];
  logic [31:0] set_pool [4];

  int phase_sb   [PHASES] = '{1, 2, 3, 8, 4, 16, 15, 5, 1, 8};
  int phase_bb   [PHASES] = '{1, 4, 5, 16, 2, 0, 31, 6, 16, 1};
  int phase_ways [PHASES] = '{1, 2, 4, 8, 8, 16, 15, 3, 8, 5};

  sacl_access_if acc_ch ();
  sacl_result_if res_ch ();
  sacl_cfg_if    cfg_ch ();

  set_assoc_cache_lru_model_unit dut (
    .clk    (clk),
    .rst    (rst),
    .access (acc_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  sacl_lru_monitor lru_mon (
    .clk           (clk),
    .rst           (rst),
    .access_mon    (acc_ch),
    .result_mon    (res_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always #2 clk = ~clk;

  task automatic send_access(input access_kind_t kind, input logic [ADDR_W-1:0] addr);
    int n;
    n = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (n > 0) begin
      acc_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    acc_ch.access_kind = kind;
    acc_ch.address = addr;
    acc_ch.valid = 1'b1;
    do @(posedge clk); while (!(acc_ch.valid && acc_ch.ready));
    @(negedge clk);
  endtask

  task automatic drain();
    acc_ch.valid = 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_ch.index = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    case (idx)
      CFG_SET_BITS:
        eff_sb = (value[3:0] < 1) ? 1 : (value[3:0] > DEF_MAX_SET_BITS) ?
                 DEF_MAX_SET_BITS : int'(value[3:0]);
      CFG_BLOCK_BITS:
        eff_bb = (value == 0) ? 1 : int'(value);
      CFG_WAYS_IN_USE:
        eff_ways = (value[3:0] < 1) ? 1 : (value[3:0] > DEF_MAX_WAYS) ?
                   DEF_MAX_WAYS : int'(value[3:0]);
      default: ;
    endcase
  endtask

  task automatic configure(input int sb, input int bb, input int ways);
    write_reg(CFG_SET_BITS, CFG_DATA_W'(sb));
    write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(bb));
    write_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(ways));
  endtask

  // mostly reuse a few tags in a few sets so hits, fills and evictions all occur
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [63:0] a;
    logic [31:0] set_mask, offset_mask;
    if ($urandom_range(0, 99) < 12) return $urandom;
    set_mask = (32'd1 << eff_sb) - 32'd1;
    offset_mask = (32'd1 << eff_bb) - 32'd1;
    a = (64'(tag_pool[$urandom_range(0, eff_ways + 2)]) << (eff_sb + eff_bb)) |
        (64'(set_pool[$urandom_range(0, 3)] & set_mask) << eff_bb) |
        64'($urandom & offset_mask);
    return a[ADDR_W-1:0];
  endfunction

  initial begin
    int n;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = stalls_on ? $urandom_range(0, GAP_MAX) : 0;
      if (n > 0) begin
        res_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    access_kind_t kind;
    rst = 1'b1;
    acc_ch.valid = 1'b0;
    acc_ch.access_kind = ACC_FETCH;
    acc_ch.address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SET_BITS;
    cfg_ch.data = '0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    eff_sb = 1;
    eff_bb = 1;
    eff_ways = 1;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    send_access(ACC_FETCH, 32'h0000_0000);
    send_access(ACC_LOAD, 32'h0000_0000);
    send_access(ACC_STORE, 32'h0000_0001);
    send_access(ACC_MODIFY, 32'hFFFF_FFFF);
    send_access(ACC_LOAD, 32'h0000_0004);
    send_access(ACC_MODIFY, 32'h0000_0004);
    send_access(ACC_FETCH, 32'hFFFF_FFFF);

    write_reg(CFG_SET_BITS, 5'd0);
    write_reg(CFG_BLOCK_BITS, 5'd0);
    write_reg(CFG_WAYS_IN_USE, 5'd0);
    write_reg(CFG_SPARE, 5'h1F);
    send_access(ACC_LOAD, 32'h0000_0008);

    configure(15, 31, 15);
    send_access(ACC_LOAD, 32'h0000_0000);
    send_access(ACC_STORE, 32'h8000_0000);
    send_access(ACC_MODIFY, 32'h7FFF_FFFF);

    configure(1, 1, 2);
    send_access(ACC_LOAD, 32'h0000_0100);
    send_access(ACC_LOAD, 32'h0000_0200);
    send_access(ACC_LOAD, 32'h0000_0100);
    send_access(ACC_STORE, 32'h0000_0300);
    send_access(ACC_LOAD, 32'h0000_0200);

    write_reg(CFG_WAYS_IN_USE, 5'd8);
    for (int k = 1; k <= 9; k++) begin
      send_access(ACC_LOAD, 32'(k) << 2);
    end

    for (int p = 0; p < PHASES; p++) begin
      configure(phase_sb[p], phase_bb[p], phase_ways[p]);
      gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      if (p == 3) begin
        gaps_on = 1'b1;
        stalls_on = 1'b1;
      end
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      foreach (set_pool[i]) set_pool[i] = $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) kind = ACC_FETCH;
        else kind = access_kind_t'($urandom_range(1, 3));
        send_access(kind, pick_address());
        if (i == PHASE_ITEMS / 2) drain();
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
